// ----- rtl/core/sabs_pkg.sv -----
// Shared types, constants and microcode table for the sorted-array binary search block.
// No dependencies; imported by sorted_array_binary_search and its testbench.
`default_nettype none

package sabs_pkg;

    localparam int DEPTH_DEFAULT       = 1024;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // position datapath: 11-bit fields plus room for sign and mid +/- 1
    localparam int POS_W = 13;
    typedef logic signed [POS_W-1:0] t_pos;
    localparam t_pos POS_ONE  = 1;
    localparam t_pos POS_ZERO = 0;

    localparam int PADDR_W = 3;

    // search_mode register codes
    typedef logic [2:0] t_mode;
    localparam t_mode MODE_EXACT = 3'd0;
    localparam t_mode MODE_FIRST = 3'd1;
    localparam t_mode MODE_LAST  = 3'd2;
    localparam t_mode MODE_LOWER = 3'd3;
    localparam t_mode MODE_UPPER = 3'd4;

    // input item op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [9:0]         load_index;
        logic signed [31:0] load_value;
        logic signed [31:0] search_key;
        logic [10:0]        range_low;
        logic [10:0]        range_high;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [10:0] position;
    } t_out_item;

    // microcode
    typedef enum logic [2:0] {
        UOP_WAIT,    // take items; a query latches its operands
        UOP_ISSUE,   // first probe read
        UOP_PROBE,   // compare, narrow the range, read next probe
        UOP_NEIGH,   // read the neighbor of an equal probe
        UOP_NCHECK,  // resolve first/last occurrence against the neighbor
        UOP_REPLY    // hand the result to the output register
    } t_uop;

    typedef logic [2:0] t_step;
    localparam t_step ST_IDLE   = 3'd0;
    localparam t_step ST_ISSUE  = 3'd1;
    localparam t_step ST_PROBE  = 3'd2;
    localparam t_step ST_NEIGH  = 3'd3;
    localparam t_step ST_NCHECK = 3'd4;
    localparam t_step ST_REPLY  = 3'd5;
    localparam int    UCODE_LEN = 6;

    // nxt: default successor, alt: exit / finish (reply: hold), aux: neighbor check
    typedef struct packed {
        t_uop  uop;
        t_step nxt;
        t_step alt;
        t_step aux;
    } t_cword;

    localparam t_cword UCODE [0:UCODE_LEN-1] = '{
        '{UOP_WAIT,   ST_ISSUE,  ST_IDLE,  ST_IDLE},
        '{UOP_ISSUE,  ST_PROBE,  ST_REPLY, ST_IDLE},
        '{UOP_PROBE,  ST_PROBE,  ST_REPLY, ST_NEIGH},
        '{UOP_NEIGH,  ST_NCHECK, ST_IDLE,  ST_IDLE},
        '{UOP_NCHECK, ST_PROBE,  ST_REPLY, ST_IDLE},
        '{UOP_REPLY,  ST_IDLE,   ST_REPLY, ST_IDLE}
    };

endpackage

`default_nettype wire

// ----- rtl/core/sorted_array_binary_search.sv -----
// Sorted-array binary search: store, microcoded search sequencer, APB mode register.
// Depends on sabs_pkg and sabs_ram.
//
// A load transfer writes one value into the store (indexes at or above DEPTH are
// dropped) and gives no result. A query transfer is answered after these steps: the
// operands are latched, the first read is issued, each probe is compared (at most
// log2(range)+1 probes), a final probe step runs when the search ends by the range
// running empty rather than by an exact hit, a neighbor check reads and then checks
// the neighbor (first/last occurrence modes only), and the output register is loaded.
// An unused mode skips the probes. The reply waits while the previous result is still
// held at the output. The store has one read port with registered data, and the next
// probe address is formed in the same cycle as the compare. Store entries power up
// undefined and are not cleared; search only what was loaded. The user must write the
// mode register (offset 0) only while the block is idle; the block does not check.
`default_nettype none

module sorted_array_binary_search #(
    parameter int DEPTH       = sabs_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = sabs_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire sabs_pkg::t_in_item             i_item,
    // output channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output sabs_pkg::t_out_item                 o_item,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sabs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    import sabs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef logic signed [VALUE_WIDTH-1:0] t_val;

    function automatic t_val to_stored(input logic signed [31:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic t_pos mid_of(input t_pos a, input t_pos b);
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        return s[POS_W:1];
    endfunction

    function automatic logic [AW-1:0] pos_addr(input t_pos p);
        logic [AW+POS_W-1:0] t;
        t = {{AW{1'b0}}, p};
        return t[AW-1:0];
    endfunction

    // control
    t_step     r_step, n_step;
    t_mode     r_mode;
    logic      r_out_valid, n_out_valid;
    t_cword    cw;

    // datapath
    t_pos      r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_pos, n_pos;
    logic      r_found, n_found;
    t_val      r_key, n_key;
    t_out_item r_out, n_out;

    // store ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [AW+9:0]     load_idx_ext;
    logic [VALUE_WIDTH-1:0] ram_q;
    t_val              q;

    logic in_xfer, cfg_wr, exact, bad_mode, cont, eq, gt, lt;
    t_pos in_lo, in_hi;

    assign cw       = UCODE[r_step];
    assign o_ready  = (cw.uop == UOP_WAIT);
    assign in_xfer  = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);
    assign prdata   = (paddr[PADDR_W-1] == 1'b0) ? {29'd0, r_mode} : 32'd0;

    assign exact    = (r_mode <= MODE_LAST);
    assign bad_mode = (r_mode > MODE_UPPER);
    assign cont     = exact ? (r_lo <= r_hi) : (r_lo < r_hi);
    assign q        = $signed(ram_q);
    assign eq       = (q == r_key);
    assign gt       = (q > r_key);
    assign lt       = (q < r_key);

    assign load_idx_ext = {{AW{1'b0}}, i_item.load_index};
    assign ram_we       = in_xfer && (i_item.op == OP_LOAD)
                          && (int'(i_item.load_index) < DEPTH);
    assign ram_waddr    = load_idx_ext[AW-1:0];

    // query operands with the range end clamped to the store
    always_comb begin
        in_lo = {2'b00, i_item.range_low};
        in_hi = {2'b00, i_item.range_high};
        if (exact && int'(i_item.range_high) > DEPTH - 1) begin
            in_hi = t_pos'(DEPTH - 1);
        end else if (!exact && int'(i_item.range_high) > DEPTH) begin
            in_hi = t_pos'(DEPTH);
        end
    end

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pos       = r_pos;
        n_found     = r_found;
        n_key       = r_key;
        ram_raddr   = pos_addr(r_mid);

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (cw.uop)
            UOP_WAIT: begin
                if (in_xfer && i_item.op == OP_QUERY) begin
                    n_key   = to_stored(i_item.search_key);
                    n_lo    = in_lo;
                    n_hi    = in_hi;
                    n_found = !exact && !bad_mode;
                    n_pos   = (!exact && !bad_mode) ? in_hi : POS_ZERO;
                    n_step  = cw.nxt;
                end
            end
            UOP_ISSUE: begin
                n_mid     = mid_of(r_lo, r_hi);
                ram_raddr = pos_addr(n_mid);
                n_step    = bad_mode ? cw.alt : cw.nxt;
            end
            UOP_PROBE: begin
                // q holds the store entry at r_mid
                if (!cont || bad_mode) begin
                    n_step = cw.alt;
                end else begin
                    n_step = cw.nxt;
                    case (r_mode)
                        MODE_EXACT: begin
                            if (eq) begin
                                n_found = 1'b1;
                                n_pos   = r_mid;
                                n_step  = cw.alt;
                            end else if (gt) begin
                                n_hi = r_mid - POS_ONE;
                            end else begin
                                n_lo = r_mid + POS_ONE;
                            end
                        end
                        MODE_FIRST: begin
                            if (eq && r_mid == r_lo) begin
                                n_found = 1'b1;
                                n_pos   = r_mid;
                                n_step  = cw.alt;
                            end else if (eq) begin
                                n_step = cw.aux;
                            end else if (lt) begin
                                n_lo = r_mid + POS_ONE;
                            end else begin
                                n_hi = r_mid - POS_ONE;
                            end
                        end
                        MODE_LAST: begin
                            if (eq && r_mid == r_hi) begin
                                n_found = 1'b1;
                                n_pos   = r_mid;
                                n_step  = cw.alt;
                            end else if (eq) begin
                                n_step = cw.aux;
                            end else if (gt) begin
                                n_hi = r_mid - POS_ONE;
                            end else begin
                                n_lo = r_mid + POS_ONE;
                            end
                        end
                        MODE_LOWER: begin
                            if (!lt) begin
                                n_pos = r_mid;
                                n_hi  = r_mid;
                            end else begin
                                n_lo = r_mid + POS_ONE;
                            end
                        end
                        default: begin
                            if (gt) begin
                                n_pos = r_mid;
                                n_hi  = r_mid;
                            end else begin
                                n_lo = r_mid + POS_ONE;
                            end
                        end
                    endcase
                    n_mid     = mid_of(n_lo, n_hi);
                    ram_raddr = pos_addr(n_mid);
                end
            end
            UOP_NEIGH: begin
                // probe equals the key; fetch the entry on the far side of it
                ram_raddr = (r_mode == MODE_FIRST) ? pos_addr(r_mid - POS_ONE)
                                                   : pos_addr(r_mid + POS_ONE);
                n_step    = cw.nxt;
            end
            UOP_NCHECK: begin
                n_step = cw.nxt;
                if (r_mode == MODE_FIRST) begin
                    if (r_key > q) begin
                        n_found = 1'b1;
                        n_pos   = r_mid;
                        n_step  = cw.alt;
                    end else begin
                        n_hi = r_mid - POS_ONE;
                    end
                end else begin
                    if (r_key < q) begin
                        n_found = 1'b1;
                        n_pos   = r_mid;
                        n_step  = cw.alt;
                    end else begin
                        n_lo = r_mid + POS_ONE;
                    end
                end
                n_mid     = mid_of(n_lo, n_hi);
                ram_raddr = pos_addr(n_mid);
            end
            UOP_REPLY: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid    = 1'b1;
                    n_out.found    = r_found;
                    n_out.position = r_pos[10:0];
                    n_step         = cw.nxt;
                end else begin
                    n_step = cw.alt;
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_EXACT;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_mode <= pwdata[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_key   <= n_key;
        r_out   <= n_out;
    end

    sabs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (to_stored(i_item.load_value)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // a result only enters the output register from the reply step
    a_out_from_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_step) == ST_REPLY)
        else $error("result loaded outside reply step");

    // a live probe always addresses a real store entry
    a_probe_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.uop == UOP_PROBE && cont && !bad_mode) |-> (r_mid >= POS_ZERO && r_mid < DEPTH))
        else $error("probe address outside store");

    // an exact-mode hit lies inside the remaining search range
    a_exact_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.uop == UOP_REPLY && exact && r_found) |-> (r_pos >= r_lo && r_pos <= r_hi))
        else $error("exact hit outside search range");

    // unused modes always reply not found at position zero
    a_bad_mode_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.uop == UOP_REPLY && bad_mode) |-> (!r_found && r_pos == POS_ZERO))
        else $error("unused mode reported found");

endmodule

`default_nettype wire

// ----- rtl/core/sabs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sabs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- tb/sv/sorted_array_binary_search_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_array_binary_search: directed vectors, a sorted fill
// of the whole store, then random loads and queries in every search mode.
// Depends on sabs_pkg and the sorted_array_binary_search RTL.

module sorted_array_binary_search_tb;
    import sabs_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FLUSH_CYCLES = 64;
    localparam logic [PADDR_W-1:0] MODE_ADDR = '0;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;
    // codes with no search behind them
    localparam t_mode MODE_RSVD5 = 3'd5;
    localparam t_mode MODE_RSVD6 = 3'd6;
    localparam t_mode MODE_RSVD7 = 3'd7;

    typedef struct {
        t_mode     mode;
        t_in_item  item;
        bit        typed;
        t_out_item answer;
    } t_vector;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_in_item          i_item;
    logic              o_valid;
    logic              i_ready;
    t_out_item         o_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    logic signed [31:0] stored_vals [0:STORE_DEPTH-1];
    t_mode              mode_now;
    t_out_item          pending_answers [$];
    t_out_item          want;
    int                 errors = 0;
    int                 cycles = 0;
    bit                 steady = 1'b0;

    sorted_array_binary_search uut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item, .o_valid, .i_ready, .o_item,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sorted_array_binary_search_tb NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b position=%0d",
                         $time, o_item.found, o_item.position);
            end else begin
                want = pending_answers.pop_front();
                if (o_item.found !== want.found) begin
                    errors++;
                    $display("%0t: found expected %0b got %0b", $time, want.found, o_item.found);
                end
                if (o_item.position !== want.position) begin
                    errors++;
                    $display("%0t: position expected %0d got %0d",
                             $time, want.position, o_item.position);
                end
            end
        end
    end

    // Shadow store entry; callers keep the index inside the store.
    function automatic logic signed [31:0] shadow_at(int i);
        return stored_vals[i[9:0]];
    endfunction

    // Expected answer of a query against the shadow store and the current mode.
    function automatic t_out_item search_result(t_in_item q);
        t_out_item          r;
        logic signed [31:0] key;
        logic signed [31:0] v;
        int                 lo;
        int                 hi;
        int                 mid;
        r   = '0;
        key = q.search_key;
        lo  = int'(q.range_low);
        hi  = int'(q.range_high);
        if (mode_now <= MODE_LAST) begin
            if (hi > STORE_DEPTH - 1) hi = STORE_DEPTH - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                v   = shadow_at(mid);
                if (v == key && (mode_now == MODE_EXACT
                        || (mode_now == MODE_FIRST && (mid == lo || key > shadow_at(mid - 1)))
                        || (mode_now == MODE_LAST && (mid == hi || key < shadow_at(mid + 1)))))
                begin
                    r.found    = 1'b1;
                    r.position = mid[10:0];
                    return r;
                end
                if (mode_now == MODE_FIRST ? v < key : v <= key) lo = mid + 1;
                else hi = mid - 1;
            end
        end else if (mode_now <= MODE_UPPER) begin
            if (hi > STORE_DEPTH) hi = STORE_DEPTH;
            r.found    = 1'b1;
            r.position = hi[10:0];
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                v   = shadow_at(mid);
                if (mode_now == MODE_UPPER ? v > key : v >= key) begin
                    r.position = mid[10:0];
                    hi         = mid;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return r;
    endfunction

    // Mostly order-keeping loads and queries aimed at stored values; the rest is noise.
    function automatic t_in_item random_item();
        t_in_item it;
        longint   lo_b;
        longint   hi_b;
        int       idx;
        int       pick;
        int       lo;
        int       hi;
        it.op         = OP_QUERY;
        it.load_index = 10'($urandom_range(STORE_DEPTH - 1));
        it.load_value = $urandom;
        it.search_key = $urandom;
        it.range_low  = 11'($urandom_range(STORE_DEPTH));
        it.range_high = 11'($urandom_range(STORE_DEPTH));
        if ($urandom_range(99) < 15) begin
            it.op = OP_LOAD;
            idx   = int'(it.load_index);
            if ($urandom_range(9) < 7) begin
                lo_b = (idx > 0) ? longint'(shadow_at(idx - 1)) : longint'(VMIN);
                hi_b = (idx < STORE_DEPTH - 1) ? longint'(shadow_at(idx + 1)) : longint'(VMAX);
                if (lo_b <= hi_b)
                    it.load_value = 32'(lo_b + longint'($urandom) % (hi_b - lo_b + 1));
            end
        end else begin
            idx  = int'($urandom_range(STORE_DEPTH - 1));
            pick = int'($urandom_range(99));
            if (pick < 60) it.search_key = shadow_at(idx);
            else if (pick < 75) it.search_key = shadow_at(idx) + ($urandom_range(1) ? 1 : -1);
            else if (pick >= 90) it.search_key = $urandom_range(1) ? VMAX : VMIN;
            pick = int'($urandom_range(99));
            lo   = int'($urandom_range(STORE_DEPTH));
            if (pick < 35) begin
                it.range_low  = 11'd0;
                it.range_high = 11'($urandom_range(1) ? STORE_DEPTH : STORE_DEPTH - 1);
            end else if (pick < 75) begin
                it.range_low  = 11'(lo);
                it.range_high = 11'($urandom_range(STORE_DEPTH, lo));
            end else if (pick < 90) begin
                hi            = lo + int'($urandom_range(3));
                it.range_low  = 11'(lo);
                it.range_high = 11'((hi > STORE_DEPTH) ? STORE_DEPTH : hi);
            end else begin
                // empty or single-entry ranges
                it.range_low  = 11'(lo);
                it.range_high = 11'($urandom_range(lo));
            end
        end
        return it;
    endfunction

    function automatic t_vector load_vec(int idx, logic signed [31:0] val);
        t_vector v;
        v.mode            = MODE_EXACT;
        v.item            = '0;
        v.item.op         = OP_LOAD;
        v.item.load_index = idx[9:0];
        v.item.load_value = val;
        v.typed           = 1'b0;
        v.answer          = '0;
        return v;
    endfunction

    function automatic t_vector query_vec(t_mode m, logic signed [31:0] key, int lo, int hi,
                                          bit typed = 1'b0, bit found = 1'b0, int pos = 0);
        t_vector v;
        v.mode              = m;
        v.item              = '0;
        v.item.op           = OP_QUERY;
        v.item.search_key   = key;
        v.item.range_low    = lo[10:0];
        v.item.range_high   = hi[10:0];
        v.typed             = typed;
        v.answer.found      = found;
        v.answer.position   = pos[10:0];
        return v;
    endfunction

    // Entered and left just after a falling edge; valid stays up between back-to-back items.
    task automatic send_item(t_in_item it, bit typed = 1'b0, t_out_item answer = '0);
        while (!steady && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (it.op == OP_LOAD) stored_vals[it.load_index] = it.load_value;
        else if (typed) pending_answers = {pending_answers, answer};
        else pending_answers = {pending_answers, search_result(it)};
        @(negedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mode changes only with the block idle: all answers in and any load retired.
    task automatic set_mode(t_mode m);
        logic [31:0] readback;
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        apb_access(1'b1, 32'(m), readback);
        mode_now = m;
        apb_access(1'b0, '0, readback);
        if (readback !== 32'(m)) begin
            errors++;
            $display("%0t: search_mode readback expected %0d got %0d", $time, m, readback);
        end
    endtask

    initial begin
        t_vector     vectors [$];
        t_mode       phase_modes [$];
        t_in_item    it;
        longint      level;
        logic [31:0] readback;
        int          k;
        int          n_items;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_item   = '0;
        i_ready  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mode_now = MODE_EXACT;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(1'b0, '0, readback);
        if (readback !== 32'(MODE_EXACT)) begin
            errors++;
            $display("%0t: search_mode after reset expected %0d got %0d",
                     $time, MODE_EXACT, readback);
        end

        // small store with the value extremes and runs of duplicates
        vectors = {vectors, load_vec(0, VMIN)};
        vectors = {vectors, load_vec(1, -5)};
        vectors = {vectors, load_vec(2, -5)};
        vectors = {vectors, load_vec(3, -5)};
        vectors = {vectors, load_vec(4, 0)};
        vectors = {vectors, load_vec(5, 7)};
        vectors = {vectors, load_vec(6, 7)};
        vectors = {vectors, load_vec(7, VMAX)};
        vectors = {vectors, query_vec(MODE_EXACT, 0, 0, 7)};
        vectors = {vectors, query_vec(MODE_EXACT, VMIN, 0, 7)};
        vectors = {vectors, query_vec(MODE_EXACT, 3, 0, 7, 1'b1, 1'b0, 0)};
        vectors = {vectors, query_vec(MODE_EXACT, 0, 1024, 1024, 1'b1, 1'b0, 0)};
        vectors = {vectors, query_vec(MODE_FIRST, -5, 0, 7)};
        vectors = {vectors, query_vec(MODE_FIRST, 7, 0, 7)};
        vectors = {vectors, query_vec(MODE_LAST, -5, 0, 7)};
        vectors = {vectors, query_vec(MODE_LAST, VMAX, 0, 7)};
        vectors = {vectors, query_vec(MODE_LOWER, 7, 0, 8)};
        vectors = {vectors, query_vec(MODE_LOWER, VMIN, 0, 8, 1'b1, 1'b1, 0)};
        vectors = {vectors, query_vec(MODE_LOWER, 0, 5, 5, 1'b1, 1'b1, 5)};
        vectors = {vectors, query_vec(MODE_LOWER, 0, 1024, 1024, 1'b1, 1'b1, 1024)};
        vectors = {vectors, query_vec(MODE_UPPER, -5, 0, 8)};
        vectors = {vectors, query_vec(MODE_UPPER, VMAX, 0, 8, 1'b1, 1'b1, 8)};
        vectors = {vectors, query_vec(MODE_RSVD7, 0, 0, 7, 1'b1, 1'b0, 0)};

        foreach (vectors[n]) begin
            if (vectors[n].item.op == OP_QUERY && vectors[n].mode != mode_now)
                set_mode(vectors[n].mode);
            send_item(vectors[n].item, vectors[n].typed, vectors[n].answer);
        end

        // ascending fill of the whole store, about a third of entries repeated
        level = longint'(VMIN);
        for (k = 0; k < STORE_DEPTH; k++) begin
            steady = (k >= 300 && k < 700);
            if (k > 0 && $urandom_range(9) >= 3) level += $urandom_range(8_400_000, 1);
            if (level > VMAX || k == STORE_DEPTH - 1) level = longint'(VMAX);
            it            = random_item();
            it.op         = OP_LOAD;
            it.load_index = k[9:0];
            it.load_value = level[31:0];
            it.search_key = $urandom;
            send_item(it);
        end
        steady = 1'b0;

        phase_modes = '{MODE_LOWER, MODE_EXACT, MODE_FIRST, MODE_RSVD5, MODE_UPPER,
                        MODE_LAST, MODE_FIRST, MODE_RSVD6, MODE_LAST, MODE_EXACT,
                        MODE_UPPER, MODE_RSVD7, MODE_LOWER};
        foreach (phase_modes[p]) begin
            set_mode(phase_modes[p]);
            steady  = (p == 4);
            n_items = (phase_modes[p] > MODE_UPPER) ? 8 : int'($urandom_range(45, 30));
            repeat (n_items) send_item(random_item());
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (FLUSH_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("sorted_array_binary_search_tb OK");
        end else begin
            $display("sorted_array_binary_search_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sabs_pkg.sv
rtl/core/sabs_ram.sv
rtl/core/sorted_array_binary_search.sv
tb/sv/sorted_array_binary_search_tb.sv
